/* rtl/core/assert_macros.svh */
// Assertion macros shared by the sine/cosine interpolator RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALW(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALW(lbl, clk, prop, msg)
`endif
`endif

/* rtl/core/sclut_pkg.sv */
// Package for the sine/cosine interpolator: default sizes, the 1/(2*pi) constant
// and the elaboration-time functions that build the sine table. No dependencies.
package sclut_pkg;

	localparam int TABLE_DEPTH   = 512;
	localparam int FRACTION_BITS = 16;

	// round(2^35/pi): angle in Q12.20 times this gives turns at bit 56.
	localparam logic [33:0] INV_TWO_PI_Q35 = 34'd10937044409;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30     = 64'd1073741824;
	localparam longint          Q15_MAX     = 64'sd32767;

	localparam longint unsigned SIN_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};
	localparam longint unsigned COS_DIV [8] = '{2, 12, 30, 56, 90, 132, 182, 240};

	// Taylor series in Q2.30 on [0, pi/2); odd selects sine, else cosine.
	function automatic longint series_q30(longint unsigned x, bit odd);
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		x2 = (x * x) >> 30;
		term = odd ? x : ONE_Q30;
		sum = longint'(term);
		for (int k = 0; k < 8; k++) begin
			term = (term * x2) >> 30;
			term = odd ? term / SIN_DIV[k] : term / COS_DIV[k];
			if ((k % 2) == 0) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		return sum;
	endfunction

	// Entry i of one sine period over 2^depth_log2 entries, Q1.15, clamped to +-32767.
	function automatic logic signed [15:0] table_entry(int unsigned i, int unsigned depth_log2);
		longint unsigned quarters;
		longint unsigned quad;
		longint unsigned rem;
		longint unsigned a;
		longint          v;
		longint          q;
		quarters = 64'(i) * 4;
		quad = (quarters >> depth_log2) & 64'd3;
		rem = quarters & ((64'd1 << depth_log2) - 64'd1);
		a = (HALF_PI_Q30 * rem) >> depth_log2;
		v = series_q30(a, (quad & 64'd1) == 64'd0);
		q = (v + 64'sd16384) >>> 15;
		if (q > Q15_MAX) begin
			q = Q15_MAX;
		end
		return (quad >= 64'd2) ? 16'(-q) : 16'(q);
	endfunction

endpackage

/* rtl/core/sclut_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sclut_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/sclut_phase.sv */
// Angle to phase stages: the 1/(2*pi) product in two partial products (s1),
// then the sum, the cosine quarter turn and the index/fraction split (s2). Uses sclut_pkg.
module sclut_phase #(
	parameter int FRACTION_BITS = sclut_pkg::FRACTION_BITS,
	parameter int IDX_W         = $clog2(sclut_pkg::TABLE_DEPTH)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     op,
	input  logic signed [31:0]       angle,
	output logic                     valid_s2,
	output logic [IDX_W-1:0]         idx_s2,
	output logic [FRACTION_BITS-1:0] frac_s2
);

	localparam logic signed [17:0] C_LO = $signed({1'b0, sclut_pkg::INV_TWO_PI_Q35[16:0]});
	localparam logic signed [17:0] C_HI = $signed({1'b0, sclut_pkg::INV_TWO_PI_Q35[33:17]});

	logic signed [49:0] mul_lo_s1;
	logic signed [49:0] mul_hi_s1;
	logic               op_s1;
	logic               valid_s1;
	logic [55:0]        sum;
	logic [31:0]        phase;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		mul_lo_s1 <= angle * C_LO;
		mul_hi_s1 <= angle * C_HI;
		op_s1     <= op;
	end

	// Only product bits 55..24 matter, so the sum is kept modulo 2^56.
	// Cosine adds a quarter turn, which sits at product bit 54.
	always_comb begin
		sum = 56'(mul_lo_s1) + {mul_hi_s1[38:0], 17'd0} + (56'(op_s1) << 54);
		phase = sum[55:24];
	end

	always_ff @(posedge clk) begin
		idx_s2  <= phase[31 -: IDX_W];
		frac_s2 <= phase[31-IDX_W -: FRACTION_BITS];
	end

endmodule

/* rtl/core/sclut_table.sv */
// Sine table in two RAM banks (even and odd entries), filled after reset, read
// at an entry and its wrapped neighbor (s3). Uses sclut_pkg and sclut_ram.
module sclut_table #(
	parameter int TABLE_DEPTH = sclut_pkg::TABLE_DEPTH,
	parameter int IDX_W       = $clog2(sclut_pkg::TABLE_DEPTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_valid,
	input  logic [IDX_W-1:0]   idx,
	output logic               busy,
	output logic               valid_s3,
	output logic signed [15:0] y0,
	output logic signed [15:0] y1
);

	localparam int BANK_DEPTH = TABLE_DEPTH / 2;
	localparam int BANK_AW    = IDX_W - 1;

	logic signed [15:0] rom_c [TABLE_DEPTH];
	logic [BANK_AW-1:0] fill_addr_q;
	logic               fill_done_q;
	logic [IDX_W-1:0]   nxt;
	logic [15:0]        even_rd;
	logic [15:0]        odd_rd;
	logic               sel_s3;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_rom
		assign rom_c[i] = sclut_pkg::table_entry(i, IDX_W);
	end

	// One row (an even and an odd entry) is written per cycle after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_addr_q <= '0;
			fill_done_q <= 1'b0;
		end else if (!fill_done_q) begin
			fill_addr_q <= fill_addr_q + 1'b1;
			if (fill_addr_q == '1) begin
				fill_done_q <= 1'b1;
			end
		end
	end

	assign busy = !fill_done_q;

	// The depth is a power of two, so the neighbor wraps by truncation.
	// Entry idx and its neighbor always have opposite parity.
	assign nxt = idx + 1'b1;

	sclut_ram #(.WIDTH(16), .DEPTH(BANK_DEPTH)) u_even (
		.clk   (clk),
		.we    (!fill_done_q),
		.waddr (fill_addr_q),
		.wdata (rom_c[{fill_addr_q, 1'b0}]),
		.raddr (nxt[IDX_W-1:1]),
		.rdata (even_rd)
	);

	sclut_ram #(.WIDTH(16), .DEPTH(BANK_DEPTH)) u_odd (
		.clk   (clk),
		.we    (!fill_done_q),
		.waddr (fill_addr_q),
		.wdata (rom_c[{fill_addr_q, 1'b1}]),
		.raddr (idx[IDX_W-1:1]),
		.rdata (odd_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= rd_valid;
		end
	end

	always_ff @(posedge clk) begin
		sel_s3 <= idx[0];
	end

	assign y0 = sel_s3 ? $signed(odd_rd) : $signed(even_rd);
	assign y1 = sel_s3 ? $signed(even_rd) : $signed(odd_rd);

endmodule

/* rtl/core/sclut_interp.sv */
// Interpolation stages: difference (s4), product with the fraction (s5),
// rounding, offset and saturation into the output register (s6). Uses sclut_pkg.
module sclut_interp #(
	parameter int FRACTION_BITS = sclut_pkg::FRACTION_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [FRACTION_BITS-1:0] frac_s2,
	input  logic                     valid_s3,
	input  logic signed [15:0]       y0,
	input  logic signed [15:0]       y1,
	output logic                     strobe,
	output logic signed [15:0]       trig_value
);

	localparam int PW = 17 + FRACTION_BITS + 1;
	localparam logic signed [PW-1:0] ROUND_C = PW'(1) << (FRACTION_BITS - 1);
	localparam logic signed [18:0]   POS_LIM = 19'(sclut_pkg::Q15_MAX);
	localparam logic signed [18:0]   NEG_LIM = -19'(sclut_pkg::Q15_MAX);

	logic [FRACTION_BITS-1:0] frac_s3;
	logic [FRACTION_BITS-1:0] frac_s4;
	logic signed [16:0]       diff_s4;
	logic signed [15:0]       y0_s4;
	logic                     valid_s4;
	logic signed [PW-1:0]     prod_s5;
	logic signed [15:0]       y0_s5;
	logic                     valid_s5;
	logic signed [PW-1:0]     acc;
	logic signed [PW-1:0]     acc_sh;
	logic signed [18:0]       r;
	logic signed [15:0]       sat;
	logic signed [15:0]       trig_value_s6;
	logic                     strobe_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			strobe_s6 <= 1'b0;
		end else begin
			valid_s4  <= valid_s3;
			valid_s5  <= valid_s4;
			strobe_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		frac_s3 <= frac_s2;
		frac_s4 <= frac_s3;
		diff_s4 <= 17'(y1) - 17'(y0);
		y0_s4   <= y0;
		prod_s5 <= diff_s4 * $signed({1'b0, frac_s4});
		y0_s5   <= y0_s4;
	end

	// Arithmetic shift gives the floor, so ties round towards plus infinity.
	always_comb begin
		acc = prod_s5 + ROUND_C;
		acc_sh = acc >>> FRACTION_BITS;
		r = 19'(y0_s5) + 19'($signed(acc_sh[17:0]));
		if (r > POS_LIM) begin
			sat = 16'(POS_LIM);
		end else if (r < NEG_LIM) begin
			sat = 16'(NEG_LIM);
		end else begin
			sat = r[15:0];
		end
	end

	always_ff @(posedge clk) begin
		trig_value_s6 <= sat;
	end

	assign strobe     = strobe_s6;
	assign trig_value = trig_value_s6;

endmodule

/* rtl/core/sine_cosine_lut_interpolator_top.sv */
// Sine/cosine table interpolator, top level.
// Commands: a beat of op (0 sine, 1 cosine) and angle (radians, signed Q12.20)
// is taken at a rising edge where start is high and busy is low.
// Results: trig_value (signed Q1.15, within +-32767) is valid for exactly one
// cycle while strobe is high; the receiver cannot hold results off, and the
// block never needs it to, since there is no internal stall.
// Throughput: one beat per cycle whenever busy is low. Pipeline: six register stages
// (two multiply/phase stages, the registered table read, the difference, the
// fraction product, the rounding and saturation register).
// Reset: arst_n clears all valid bits. The table RAMs then fill one row of an
// even and an odd entry per cycle, TABLE_DEPTH/2 rows (256 at the default
// depth), and busy stays high until that pass ends.
// TABLE_DEPTH must be a power of two; FRACTION_BITS plus its log2 is at most 32.
// Uses sclut_pkg, sclut_phase, sclut_table, sclut_interp and assert_macros.svh.
`include "assert_macros.svh"

module sine_cosine_lut_interpolator_top #(
	parameter int TABLE_DEPTH   = sclut_pkg::TABLE_DEPTH,
	parameter int FRACTION_BITS = sclut_pkg::FRACTION_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               op,
	input  logic signed [31:0] angle,
	output logic               strobe,
	output logic signed [15:0] trig_value
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	logic                     accept;
	logic                     valid_s2;
	logic [IDX_W-1:0]         idx_s2;
	logic [FRACTION_BITS-1:0] frac_s2;
	logic                     valid_s3;
	logic signed [15:0]       y0;
	logic signed [15:0]       y1;

	assign accept = start && !busy;

	sclut_phase #(.FRACTION_BITS(FRACTION_BITS), .IDX_W(IDX_W)) u_phase (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.op       (op),
		.angle    (angle),
		.valid_s2 (valid_s2),
		.idx_s2   (idx_s2),
		.frac_s2  (frac_s2)
	);

	sclut_table #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_valid (valid_s2),
		.idx      (idx_s2),
		.busy     (busy),
		.valid_s3 (valid_s3),
		.y0       (y0),
		.y1       (y1)
	);

	sclut_interp #(.FRACTION_BITS(FRACTION_BITS)) u_interp (
		.clk        (clk),
		.arst_n     (arst_n),
		.frac_s2    (frac_s2),
		.valid_s3   (valid_s3),
		.y0         (y0),
		.y1         (y1),
		.strobe     (strobe),
		.trig_value (trig_value)
	);

	`ASSERT_CHK(a_latency, clk, arst_n, accept |-> ##6 strobe, "result missing six cycles after a beat")
	`ASSERT_CHK(a_fill_once, clk, arst_n, !busy |=> !busy, "busy rose again after the table fill")
	`ASSERT_CHK(a_no_result_in_fill, clk, arst_n, busy |-> !strobe, "result during the table fill")
	`ASSERT_CHK(a_saturated, clk, arst_n, strobe |-> (trig_value != 16'sh8000), "result not saturated")
	`ASSERT_ALW(a_reset_quiet, clk, !arst_n |-> (!strobe && busy), "reset left a result or cleared busy")

endmodule

/* verif/sine_cosine_lut_interpolator_top_tb.sv */
// Self-checking testbench for sine_cosine_lut_interpolator_top.
// It predicts each sine or cosine sample from its own copy of the table and checks it.
// Depends on sclut_pkg for the table depth, fraction width and phase constants.
module sine_cosine_lut_interpolator_top_tb;

	localparam int DEPTH          = sclut_pkg::TABLE_DEPTH;
	localparam int FBITS          = sclut_pkg::FRACTION_BITS;
	localparam int Q15_LIMIT      = 32767;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 12;
	localparam int RANDOM_BEATS   = 330;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	// One full turn and a quarter turn in Q12.20 radians, rounded.
	localparam int TWO_PI_Q20  = 6588397;
	localparam int HALF_PI_Q20 = 1647099;

	typedef enum bit {
		OP_SINE   = 1'b0,
		OP_COSINE = 1'b1
	} trig_op_t;

	typedef struct {
		trig_op_t           kind;
		logic signed [31:0] ang;
		logic signed [15:0] value;
	} trig_expect_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b1;
	logic               start = 1'b0;
	logic               op = 1'b0;
	logic signed [31:0] angle = '0;
	logic               busy;
	logic               strobe;
	logic signed [15:0] trig_value;

	trig_expect_t       pending_trig[$];
	logic signed [15:0] sine_rom [DEPTH];
	int                 error_count = 0;
	int                 sent_count = 0;
	int                 checked_count = 0;
	int                 idle_pct = 0;
	int                 quiet_cycles = 0;

	sine_cosine_lut_interpolator_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.angle      (angle),
		.strobe     (strobe),
		.trig_value (trig_value)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Q2.30 Taylor series on [0, pi/2); odd_terms gives sine, otherwise cosine.
	function automatic longint taylor_q30(longint unsigned x, bit odd_terms);
		longint unsigned x_sq;
		longint unsigned term;
		longint unsigned n;
		longint          acc;
		x_sq = (x * x) >> 30;
		term = odd_terms ? x : (64'd1 << 30);
		acc = longint'(term);
		n = odd_terms ? 64'd1 : 64'd0;
		for (int k = 1; k <= 8; k++) begin
			term = (term * x_sq) >> 30;
			term = term / ((n + 1) * (n + 2));
			n = n + 2;
			if (k % 2) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		return (acc < 0) ? 64'sd0 : acc;
	endfunction

	// One table entry: the quadrant picks the series and the sign.
	function automatic logic signed [15:0] rom_entry(int unsigned i);
		longint unsigned quarters;
		longint unsigned quad;
		longint unsigned rem;
		longint unsigned arg;
		longint          v;
		longint          q;
		quarters = 64'(i) * 4;
		quad = (quarters / DEPTH) & 64'd3;
		rem = quarters % DEPTH;
		arg = (sclut_pkg::HALF_PI_Q30 * rem) / DEPTH;
		v = taylor_q30(arg, (quad & 64'd1) == 64'd0);
		q = (v + 64'sd16384) >>> 15;
		if (q > Q15_LIMIT) begin
			q = Q15_LIMIT;
		end
		return (quad >= 64'd2) ? 16'(-q) : 16'(q);
	endfunction

	function automatic logic signed [15:0] interpolate_trig(trig_op_t kind,
			logic signed [31:0] ang);
		longint unsigned ang64;
		longint unsigned prod;
		longint unsigned scaled;
		logic [31:0]     phase;
		int unsigned     idx;
		int unsigned     nxt;
		longint          frac;
		longint          y0;
		longint          y1;
		longint          acc;
		longint          r;
		ang64 = longint'(ang);
		prod = ang64 * 64'(sclut_pkg::INV_TWO_PI_Q35);
		phase = prod[55:24];
		if (kind == OP_COSINE) begin
			phase = phase + QUARTER_TURN;
		end
		scaled = 64'(phase) * 64'(DEPTH);
		idx = int'(scaled >> 32);
		nxt = (idx + 1 == DEPTH) ? 0 : idx + 1;
		frac = longint'((scaled & 64'hFFFF_FFFF) >> (32 - FBITS));
		y0 = sine_rom[idx];
		y1 = sine_rom[nxt];
		// Arithmetic shift of a signed sum floors, so ties round up.
		acc = (y1 - y0) * frac + (64'sd1 <<< (FBITS - 1));
		r = y0 + (acc >>> FBITS);
		if (r > Q15_LIMIT) begin
			r = Q15_LIMIT;
		end
		if (r < -Q15_LIMIT) begin
			r = -Q15_LIMIT;
		end
		return 16'(r);
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Holds one command until busy lets it in, then idles the sender at random.
	task automatic send_trig(trig_op_t kind, logic signed [31:0] ang);
		trig_expect_t e;
		start <= 1'b1;
		op <= kind;
		angle <= ang;
		do @(posedge clk); while (busy);
		e.kind = kind;
		e.ang = ang;
		e.value = interpolate_trig(kind, ang);
		pending_trig.push_back(e);
		sent_count++;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			op <= 1'($urandom_range(1));
			angle <= $urandom;
			@(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] random_angle();
		int k;
		k = int'($urandom_range(80)) - 40;
		case ($urandom_range(3))
			0: return $urandom;
			1: return int'($urandom_range(2 * TWO_PI_Q20)) - TWO_PI_Q20;
			// Near quadrant boundaries, where the table turns over.
			2: return k * HALF_PI_Q20 + int'($urandom_range(64)) - 32;
			// Just below whole turns, which can read the last entry and wrap to entry 0.
			default: return (k / 4) * TWO_PI_Q20 - int'($urandom_range(16384));
		endcase
	endfunction

	task automatic run_random_beats(int count);
		for (int n = 0; n < count; n++) begin
			send_trig(trig_op_t'($urandom_range(1)), random_angle());
		end
	endtask

	task automatic test_directed_points();
		logic signed [31:0] points [13];
		points = '{32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
			HALF_PI_Q20, 2 * HALF_PI_Q20, -HALF_PI_Q20, TWO_PI_Q20 - 1,
			TWO_PI_Q20, -TWO_PI_Q20, 32'sh4000_0000, 32'shC000_0000};
		idle_pct = 0;
		foreach (points[i]) begin
			send_trig(OP_SINE, points[i]);
			send_trig(OP_COSINE, points[i]);
		end
	endtask

	task automatic test_back_to_back();
		idle_pct = 0;
		run_random_beats(RANDOM_BEATS);
	endtask

	task automatic test_sparse_sender();
		idle_pct = 64;
		run_random_beats(RANDOM_BEATS);
	endtask

	task automatic test_light_gaps();
		idle_pct = 25;
		run_random_beats(RANDOM_BEATS);
	endtask

	always @(posedge clk) begin
		trig_expect_t e;
		if (arst_n && strobe) begin
			if (pending_trig.size() == 0) begin
				report_mismatch($sformatf("trig_value %0d with nothing expected", trig_value));
			end else begin
				e = pending_trig.pop_front();
				checked_count++;
				if (trig_value !== e.value) begin
					report_mismatch($sformatf("%s angle=%h: trig_value %0d, expected %0d",
						e.kind.name(), e.ang, trig_value, e.value));
				end
			end
		end
	end

	// Counts cycles in which no beat goes either way.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: %0d cycles without a beat, %0d results outstanding",
				quiet_cycles, pending_trig.size());
			$display("FAIL sine_cosine_lut_interpolator_top");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			sine_rom[i] = rom_entry(i);
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_points();
		test_back_to_back();
		test_sparse_sender();
		test_light_gaps();
		start <= 1'b0;
		while (pending_trig.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d sine and cosine commands: directed angles, then random ones",
			sent_count);
		$display("back to back and with sender gaps; %0d results checked, %0d mismatches.",
			checked_count, error_count);
		if (error_count == 0) begin
			$display("PASS sine_cosine_lut_interpolator_top");
		end else begin
			$display("FAIL sine_cosine_lut_interpolator_top");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/sclut_pkg.sv
rtl/core/sclut_ram.sv
rtl/core/sclut_phase.sv
rtl/core/sclut_table.sv
rtl/core/sclut_interp.sv
rtl/core/sine_cosine_lut_interpolator_top.sv
verif/sine_cosine_lut_interpolator_top_tb.sv
